[rtl/core/atpf_pkg.sv]
// Shared types and constants for the ARCNET transmit page formatter.
// Used by every module in rtl/core; it depends on nothing else.
package atpf_pkg;

	// Command codes carried in the input tuser bit.
	typedef enum logic {
		CMD_START = 1'b0,
		CMD_DATA  = 1'b1
	} cmd_t;

	// Result kinds carried in the output tuser bit.
	typedef enum logic {
		KIND_STATUS = 1'b0,
		KIND_WORD   = 1'b1
	} kind_t;

	// Status codes returned for a start word.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BUSY     = 2'd1,
		ST_LEN_ERR  = 2'd2,
		ST_RESERVED = 2'd3
	} status_t;

	// Frame layout constants.
	localparam logic [9:0] SHORT_MAX   = 10'd253;
	localparam logic [9:0] PAD_LOW     = 10'd254;
	localparam logic [9:0] PAD_TARGET  = 10'd257;
	localparam logic [9:0] SHORT_PAGE  = 10'h100;
	localparam logic [9:0] LONG_PAGE   = 10'h200;
	localparam logic [1:0] TOP_LANE    = 2'h3;

	// One input word after unpacking.
	typedef struct packed {
		cmd_t        command;
		logic [7:0]  dest_node;
		logic [9:0]  msg_length;
		logic        tx_available;
		logic [7:0]  data_byte;
	} item_t;

	// One result word before packing.
	typedef struct packed {
		kind_t       kind;
		status_t     status;
		logic [6:0]  page_word;
		logic [31:0] word_data;
		logic        last;
	} result_t;

endpackage

[rtl/core/atpf_in_reg.sv]
// Input register stage of the ARCNET transmit page formatter.
// Depends on atpf_pkg for the item type.
module atpf_in_reg
	import atpf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	// The stage takes a new word when empty or when its word moves on.
	assign in_ready = !valid_s1 || advance;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

[rtl/core/atpf_format.sv]
// Message state and result logic of the ARCNET transmit page formatter.
// Depends on atpf_pkg for the item, result and status types.
module atpf_format
	import atpf_pkg::*;
#(
	parameter int MAX_LENGTH = 508
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] own_node_id,
	input  logic       advance,
	input  item_t      item_s1,
	output logic       has_result,
	output result_t    result
);

	localparam logic [9:0] MaxLen = 10'(MAX_LENGTH);

	logic        in_message_q;
	logic [8:0]  byte_position_q;
	logic [9:0]  bytes_remaining_q;
	logic [23:0] word_accumulator_q;

	logic        len_bad;
	logic [9:0]  padded;
	logic        is_short;
	logic [7:0]  short_count;
	logic [8:0]  long_count;
	logic [8:0]  start_pos;
	logic [31:0] header;
	logic [1:0]  lane;
	logic [31:0] word;
	logic        final_byte;

	// Start word: length check, padding and header layout.
	always_comb begin
		len_bad     = (item_s1.msg_length == 10'd0) || (item_s1.msg_length > MaxLen);
		padded      = (item_s1.msg_length >= PAD_LOW && item_s1.msg_length < PAD_TARGET)
			? PAD_TARGET : item_s1.msg_length;
		is_short    = padded <= SHORT_MAX;
		short_count = 8'(SHORT_PAGE - padded);
		long_count  = 9'(LONG_PAGE - padded);
		if (is_short) begin
			start_pos = {1'b0, short_count};
			header    = {8'h00, short_count, item_s1.dest_node, own_node_id};
		end else begin
			start_pos = long_count;
			header    = {long_count[7:0], 8'h00, item_s1.dest_node, own_node_id};
		end
	end

	// Data word: place the byte in its lane on top of the lanes so far.
	always_comb begin
		lane       = byte_position_q[1:0];
		word       = {8'h00, word_accumulator_q} | (32'(item_s1.data_byte) << {lane, 3'b000});
		final_byte = bytes_remaining_q <= 10'd1;
	end

	// Result selection.
	always_comb begin
		has_result       = 1'b0;
		result.kind      = KIND_STATUS;
		result.status    = ST_OK;
		result.page_word = 7'd0;
		result.word_data = 32'd0;
		result.last      = 1'b0;
		unique case (item_s1.command)
			CMD_START: begin
				has_result = 1'b1;
				if (!item_s1.tx_available) begin
					result.status = ST_BUSY;
				end else if (len_bad) begin
					result.status = ST_LEN_ERR;
				end else begin
					result.word_data = header;
				end
			end
			CMD_DATA: begin
				has_result       = in_message_q && (final_byte || lane == TOP_LANE);
				result.kind      = KIND_WORD;
				result.page_word = byte_position_q[8:2];
				result.word_data = word;
				result.last      = final_byte;
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
	end

	// Message state update on every word that leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_message_q       <= 1'b0;
			byte_position_q    <= 9'd0;
			bytes_remaining_q  <= 10'd0;
			word_accumulator_q <= 24'd0;
		end else if (advance) begin
			if (item_s1.command == CMD_START) begin
				if (item_s1.tx_available && !len_bad) begin
					in_message_q       <= 1'b1;
					byte_position_q    <= start_pos;
					bytes_remaining_q  <= item_s1.msg_length;
					word_accumulator_q <= 24'd0;
				end
			end else if (in_message_q) begin
				byte_position_q <= byte_position_q + 9'd1;
				if (final_byte) begin
					in_message_q       <= 1'b0;
					bytes_remaining_q  <= 10'd0;
					word_accumulator_q <= 24'd0;
				end else begin
					bytes_remaining_q  <= bytes_remaining_q - 10'd1;
					word_accumulator_q <= (lane == TOP_LANE) ? 24'd0 : word[23:0];
				end
			end
		end
	end

endmodule

[rtl/core/atpf_out_reg.sv]
// Output register of the ARCNET transmit page formatter.
// Depends on atpf_pkg for the result type.
module atpf_out_reg
	import atpf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t load_result,
	output logic    room,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_result
);

	logic    valid_q;
	result_t result_q;

	// A new result may enter when the register is empty or being drained.
	assign room       = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= load_result;
		end
	end

endmodule

[rtl/core/arcnet_tx_page_formatter.sv]
// Top level of the ARCNET transmit page formatter.
// Depends on atpf_pkg, atpf_in_reg, atpf_format and atpf_out_reg.
//
//  channel | direction | handshake           | payload
//  s_*     | in        | s_tvalid / s_tready | tuser command, tdata start/data fields
//  m_*     | out       | m_tvalid / m_tready | tuser kind, tdata result, tlast last
//  cfg_*   | in        | cfg_valid/cfg_ready | cfg_data own node id
//
// One word is accepted per cycle while the input stage is ready; a result passes
// from its input word through the input register and then the output register.
// Throughput is set by the output register: a stalled result holds the input
// stage only when the word behind it produces a result of its own.
// Reset clears the message state, the node id and both valid flags at once.
module arcnet_tx_page_formatter
	import atpf_pkg::*;
#(
	parameter int MAX_LENGTH = 508
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,  // command
	input  logic [31:0] s_tdata,  // dest_node, msg_length, tx_available, data_byte, zeros
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic        m_tuser,  // kind
	output logic [47:0] m_tdata,  // status, page_word, word_data, zeros
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	logic [7:0] own_node_id_q;
	item_t      in_item;
	item_t      item_s1;
	logic       valid_s1;
	logic       advance;
	logic       room;
	logic       has_result;
	result_t    result;
	result_t    out_result;

	// Node id register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_node_id_q <= 8'd0;
		end else if (cfg_valid) begin
			own_node_id_q <= cfg_data;
		end
	end

	// Unpack the input word.
	always_comb begin
		in_item.command      = cmd_t'(s_tuser);
		in_item.dest_node    = s_tdata[7:0];
		in_item.msg_length   = s_tdata[17:8];
		in_item.tx_available = s_tdata[18];
		in_item.data_byte    = s_tdata[26:19];
	end

	// A word moves on when it yields nothing or the output register can take its result.
	assign advance = valid_s1 && (room || !has_result);

	atpf_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	atpf_format #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_format (
		.clk         (clk),
		.arst_n      (arst_n),
		.own_node_id (own_node_id_q),
		.advance     (advance),
		.item_s1     (item_s1),
		.has_result  (has_result),
		.result      (result)
	);

	atpf_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance && has_result),
		.load_result (result),
		.room        (room),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_result  (out_result)
	);

	// Pack the result word.
	assign m_tuser = out_result.kind;
	assign m_tlast = out_result.last;
	assign m_tdata = {7'd0, out_result.word_data, out_result.page_word, out_result.status};

endmodule

[rtl/core/atpf_checker.sv]
// Port-level checks for the ARCNET transmit page formatter, bound to the top.
// Depends on atpf_pkg for the kind and status codes and on the top level's ports.
module atpf_checker
	import atpf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic        m_tuser,
	input logic [47:0] m_tdata,
	input logic        m_tlast
);

	// A stalled result holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// A status result is never flagged as the final word.
	a_status_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_STATUS |-> !m_tlast)
		else $error("status result flagged last");

	// A status result always refers to the header word.
	a_status_header: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_STATUS |-> m_tdata[8:2] == 7'd0)
		else $error("status result with nonzero page word");

	// A data word always carries an ok status.
	a_word_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_WORD |-> m_tdata[1:0] == ST_OK)
		else $error("data word with nonzero status");

	// A rejected start carries an empty word and a known code.
	a_reject_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_STATUS && m_tdata[1:0] != ST_OK
			|-> m_tdata[40:9] == 32'd0 && m_tdata[1:0] != ST_RESERVED)
		else $error("bad rejected status result");

endmodule

bind arcnet_tx_page_formatter atpf_checker u_atpf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tuser  (m_tuser),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

[dv/testbench.sv]
// Self-checking testbench for the ARCNET transmit page formatter.
// Drives start and data words over the input stream, predicts every status and page word,
// and checks the output stream in order. Depends on atpf_pkg and arcnet_tx_page_formatter.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import atpf_pkg::*;

	localparam int MAX_LEN      = 508;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 40;

	// Predicts page words from accepted input words and checks the output words in order.
	class page_scoreboard;
		result_t    pending_words[$];
		logic [7:0] node_id;
		bit         in_msg;
		logic [8:0] byte_pos;
		logic [9:0] bytes_left;
		logic [1:0] pad_left;
		logic [23:0] lanes_acc;
		int         errors;

		function new();
			node_id = '0;
			in_msg = 1'b0;
			byte_pos = '0;
			bytes_left = '0;
			pad_left = '0;
			lanes_acc = '0;
			errors = 0;
		endfunction

		function int pending();
			return pending_words.size();
		endfunction

		// Works out the result, if any, of one accepted input word.
		function void note_item(item_t it);
			result_t     r;
			logic [9:0]  padded;
			logic [9:0]  span;
			logic [9:0]  pad_diff;
			logic [31:0] word;
			logic [6:0]  pw;
			logic [1:0]  lane;
			bit          is_final;
			r = '0;
			if (it.command == CMD_START) begin
				r.kind = KIND_STATUS;
				if (!it.tx_available) begin
					r.status = ST_BUSY;
				end else if (it.msg_length == 0 || it.msg_length > MAX_LEN) begin
					r.status = ST_LEN_ERR;
				end else begin
					// Lengths just above the short limit are padded to the first long length.
					padded = (it.msg_length > SHORT_MAX && it.msg_length < PAD_TARGET) ?
						PAD_TARGET : it.msg_length;
					if (padded < PAD_LOW) begin
						span = SHORT_PAGE - padded;
						byte_pos = {1'b0, span[7:0]};
						r.word_data = {8'h00, span[7:0], it.dest_node, node_id};
					end else begin
						span = LONG_PAGE - padded;
						byte_pos = span[8:0];
						r.word_data = {span[7:0], 8'h00, it.dest_node, node_id};
					end
					pad_diff = padded - it.msg_length;
					in_msg = 1'b1;
					bytes_left = it.msg_length;
					pad_left = pad_diff[1:0];
					lanes_acc = '0;
					r.status = ST_OK;
				end
				pending_words.push_back(r);
			end else if (in_msg) begin
				lane = byte_pos[1:0];
				word = {8'h00, lanes_acc} | ({24'h0, it.data_byte} << (8 * lane));
				is_final = (bytes_left <= 1);
				pw = byte_pos[8:2];
				byte_pos = byte_pos + 1'b1;
				bytes_left = bytes_left - 1'b1;
				r.kind = KIND_WORD;
				r.status = ST_OK;
				r.page_word = pw;
				r.word_data = word;
				if (is_final) begin
					in_msg = 1'b0;
					bytes_left = '0;
					pad_left = '0;
					lanes_acc = '0;
					r.last = 1'b1;
					pending_words.push_back(r);
				end else if (lane == TOP_LANE) begin
					lanes_acc = '0;
					pending_words.push_back(r);
				end else begin
					lanes_acc = word[23:0];
				end
			end
		endfunction

		// Compares one accepted output word with the oldest prediction.
		function void check_word(result_t got);
			result_t want;
			if (pending_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected output word: kind %0d status %0d %s %0d data %h last %0d",
						got.kind, got.status, "page_word", got.page_word,
						got.word_data, got.last);
				return;
			end
			want = pending_words.pop_front();
			if (got.kind !== want.kind || got.status !== want.status ||
					got.page_word !== want.page_word || got.word_data !== want.word_data ||
					got.last !== want.last) begin
				errors++;
				if (errors <= 10) begin
					$write("word differs: expected kind %0d status %0d page_word %0d",
						want.kind, want.status, want.page_word);
					$write(" data %h last %0d,", want.word_data, want.last);
					$write(" got kind %0d status %0d page_word %0d",
						got.kind, got.status, got.page_word);
					$display(" data %h last %0d", got.word_data, got.last);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic        s_tuser = 1'b0;   // command
	logic [31:0] s_tdata = '0;     // dest_node, msg_length, tx_available, data_byte, zeros
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic        m_tuser;          // kind
	logic [47:0] m_tdata;          // status, page_word, word_data, zeros
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = '0;

	page_scoreboard sb = new();
	int cycle_count = 0;
	bit hold_request = 1'b0;
	int counted = 0;

	arcnet_tx_page_formatter #(
		.MAX_LENGTH(MAX_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tuser(m_tuser),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// A window of cycles in which neither side idles.
	function automatic bit no_idle_window();
		return cycle_count >= 500 && cycle_count < 900;
	endfunction

	// Input word with every field random; callers override the fields that matter.
	function automatic item_t random_item();
		item_t it;
		it.command = cmd_t'($urandom_range(0, 1));
		it.dest_node = 8'($urandom_range(0, 255));
		it.msg_length = 10'($urandom_range(0, 1023));
		it.tx_available = 1'($urandom_range(0, 1));
		it.data_byte = 8'($urandom_range(0, 255));
		return it;
	endfunction

	function automatic item_t start_item(logic [7:0] dest, logic [9:0] len, logic avail);
		item_t it;
		it = random_item();
		it.command = CMD_START;
		it.dest_node = dest;
		it.msg_length = len;
		it.tx_available = avail;
		return it;
	endfunction

	function automatic item_t data_item();
		item_t it;
		it = random_item();
		it.command = CMD_DATA;
		return it;
	endfunction

	// Message length: mostly short, some around the padding range, a few long.
	function automatic int pick_length();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 85)
			return $urandom_range(1, 12);
		else if (sel < 92)
			return $urandom_range(251, 258);
		else if (sel < 94)
			return $urandom_range(257, MAX_LEN);
		else
			return $urandom_range(1, 64);
	endfunction

	// Offers one input word after a random gap and waits until it is accepted.
	task automatic send_item(item_t it);
		while (!no_idle_window() && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.command;
		s_tdata <= {5'b0, it.data_byte, it.tx_available, it.msg_length, it.dest_node};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_item(it);
	endtask

	// A start word followed by nbytes data words.
	task automatic send_message(logic [7:0] dest, int len, int nbytes);
		send_item(start_item(dest, len[9:0], 1'b1));
		for (int i = 0; i < nbytes; i++)
			send_item(data_item());
	endtask

	// Holds the sender until every predicted word has arrived and the pipeline is empty.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_node_id(logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.node_id = value;
	endtask

	// Output side: checks accepted words and applies random and long back-pressure.
	initial begin
		int hold_left;
		result_t got;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.kind = kind_t'(m_tuser);
				got.status = status_t'(m_tdata[1:0]);
				got.page_word = m_tdata[8:2];
				got.word_data = m_tdata[40:9];
				got.last = m_tlast;
				sb.check_word(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_idle_window() || $urandom_range(0, 99) >= 10;
			end
		end
	end

	// Stimulus: directed cases, then random phases with different node ids.
	initial begin
		int sel;
		int len;
		int nbytes;
		int goal;
		logic [7:0] ids [4];
		ids[0] = 8'h00;
		ids[1] = 8'hFF;
		ids[2] = 8'($urandom_range(1, 254));
		ids[3] = 8'($urandom_range(0, 255));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_node_id(8'hA5);

		// Stray data, busy, length errors, padding, abandoned and complete messages.
		send_item(data_item());
		send_item(start_item(8'h12, 10'd20, 1'b0));
		send_item(start_item(8'h34, 10'd0, 1'b0));
		send_item(start_item(8'h00, 10'd0, 1'b1));
		send_item(start_item(8'hFF, 10'(MAX_LEN + 1), 1'b1));
		send_item(start_item(8'h56, 10'h3FF, 1'b1));
		send_message(8'hFF, 1, 1);
		send_message(8'h01, 253, 2);
		send_message(8'h02, 254, 2);
		send_message(8'h03, 256, 1);
		send_message(8'hFF, MAX_LEN, 3);
		send_message(8'h04, 257, 1);
		send_message(8'h00, 5, 5);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			write_node_id(ids[phase]);
			if (phase == 1)
				hold_request = 1'b1;
			goal = counted + PHASE_ITEMS;
			if (phase == 2) begin
				// One full long message fills a whole page.
				send_message(8'($urandom_range(0, 255)), MAX_LEN, MAX_LEN);
				counted += MAX_LEN + 1;
			end
			while (counted < goal) begin
				sel = $urandom_range(0, 99);
				if (sel < 72) begin
					len = pick_length();
					send_message(8'($urandom_range(0, 255)), len, len);
					counted += len + 1;
				end else if (sel < 80) begin
					// Message cut short; the next start abandons it.
					len = pick_length();
					nbytes = $urandom_range(0, len - 1);
					send_message(8'($urandom_range(0, 255)), len, nbytes);
					counted += nbytes + 1;
				end else if (sel < 88) begin
					if ($urandom_range(0, 1))
						len = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_LEN + 1, 1023);
					else
						len = $urandom_range(0, 1023);
					send_item(start_item(8'($urandom_range(0, 255)), len[9:0],
						1'($urandom_range(0, 1))));
					counted++;
				end else if (sel < 94) begin
					// Data words that may find no open message.
					repeat ($urandom_range(1, 3)) send_item(data_item());
				end else begin
					send_item(random_item());
					counted++;
				end
			end
			wait_drained();
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("arcnet_tx_page_formatter: match");
		end else begin
			$display("arcnet_tx_page_formatter: mismatch");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2_000_000;
		$display("arcnet_tx_page_formatter: mismatch");
		$finish;
	end

endmodule
